### hdl/bot_pkg.sv
// bot_pkg: shared types and constants of the bulk-only transport sequencer
// no dependencies; imported by all modules, while the interfaces do not import it
`timescale 1ns / 1ps
`default_nettype none

package bot_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COMMAND_TAG   = 2'd0,
      CSR_SHORT_TIMEOUT = 2'd1,
      CSR_READ_TIMEOUT  = 2'd2,
      CSR_WRITE_TIMEOUT = 2'd3
   } csr_index_type;

   localparam logic [31:0] COMMAND_TAG_RESET   = 32'h1234_5678;
   localparam logic [15:0] SHORT_TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] READ_TIMEOUT_RESET  = 16'd4000;
   localparam logic [15:0] WRITE_TIMEOUT_RESET = 16'd10000;

   localparam logic [31:0] WRAPPER_BYTES    = 32'd31;
   localparam logic [31:0] STATUS_BYTES     = 32'd13;
   localparam logic [31:0] STATUS_SIGNATURE = 32'h5342_5355;
   localparam logic [7:0]  STATUS_GOOD      = 8'h00;

   typedef enum logic {
      OP_START    = 1'b0,
      OP_COMPLETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_WRAPPER = 2'd1,
      PH_DATA    = 2'd2,
      PH_STATUS  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE         = 3'd0,
      ACT_SEND_WRAPPER = 3'd1,
      ACT_READ_DATA    = 3'd2,
      ACT_WRITE_DATA   = 3'd3,
      ACT_READ_STATUS  = 3'd4,
      ACT_SUCCESS      = 3'd5,
      ACT_ERROR        = 3'd6,
      ACT_BUSY         = 3'd7
   } action_type;

   typedef struct packed {
      logic [31:0] command_tag;
      logic [15:0] short_timeout;
      logic [15:0] read_timeout;
      logic [15:0] write_timeout;
   } cfg_type;

   typedef struct packed {
      logic        op;
      logic [6:0]  usb_addr;
      logic        direction;
      logic [31:0] data_bytes;
      logic        transfer_ok;
      logic [31:0] status_signature;
      logic [31:0] status_tag;
      logic [31:0] status_residue;
      logic [7:0]  status_code;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [6:0]  target_address;
      logic [31:0] byte_count;
      logic [15:0] timeout_ms;
      logic        close_pipes;
   } rsp_item_type;

endpackage

`default_nettype wire

### hdl/bot_if.sv
// bot_req_if and bot_rsp_if: valid/ready channels of the sequencer
// no package dependency; fields follow the item layout of bot_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bot_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [6:0]  usb_addr;
   logic        direction;
   logic [31:0] data_bytes;
   logic        transfer_ok;
   logic [31:0] status_signature;
   logic [31:0] status_tag;
   logic [31:0] status_residue;
   logic [7:0]  status_code;

   modport source (
      output valid, op, usb_addr, direction, data_bytes, transfer_ok,
             status_signature, status_tag, status_residue, status_code,
      input  ready
   );
   modport sink (
      input  valid, op, usb_addr, direction, data_bytes, transfer_ok,
             status_signature, status_tag, status_residue, status_code,
      output ready
   );
endinterface

interface bot_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [6:0]  target_address;
   logic [31:0] byte_count;
   logic [15:0] timeout_ms;
   logic        close_pipes;

   modport source (
      output valid, action, target_address, byte_count, timeout_ms, close_pipes,
      input  ready
   );
   modport sink (
      input  valid, action, target_address, byte_count, timeout_ms, close_pipes,
      output ready
   );
endinterface

`default_nettype wire

### hdl/bot_csr.sv
// bot_csr: configuration registers of the sequencer
// depends on bot_pkg
`timescale 1ns / 1ps
`default_nettype none

module bot_csr
   import bot_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_COMMAND_TAG:   cfg_in.command_tag   = csr_write_data;
            CSR_SHORT_TIMEOUT: cfg_in.short_timeout = csr_write_data[15:0];
            CSR_READ_TIMEOUT:  cfg_in.read_timeout  = csr_write_data[15:0];
            CSR_WRITE_TIMEOUT: cfg_in.write_timeout = csr_write_data[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_tag   <= COMMAND_TAG_RESET;
         cfg_ff.short_timeout <= SHORT_TIMEOUT_RESET;
         cfg_ff.read_timeout  <= READ_TIMEOUT_RESET;
         cfg_ff.write_timeout <= WRITE_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hdl/bot_seq.sv
// bot_seq: input register, transport phase logic and result register
// depends on bot_pkg and the channel interfaces in bot_if
`timescale 1ns / 1ps
`default_nettype none

module bot_seq
   import bot_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  cfg_type   cfg,
   bot_req_if.sink   req_chan,
   bot_rsp_if.source rsp_chan
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   phase_type    phase_ff, phase_in;
   logic         read_dir_ff, read_dir_in;
   logic [31:0]  data_len_ff, data_len_in;
   logic [6:0]   device_ff, device_in;

   logic         exe_fire;
   logic         req_fire;
   logic         status_good;

   assign exe_fire = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || exe_fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.op               <= req_chan.op;
         in_item_ff.usb_addr         <= req_chan.usb_addr;
         in_item_ff.direction        <= req_chan.direction;
         in_item_ff.data_bytes       <= req_chan.data_bytes;
         in_item_ff.transfer_ok      <= req_chan.transfer_ok;
         in_item_ff.status_signature <= req_chan.status_signature;
         in_item_ff.status_tag       <= req_chan.status_tag;
         in_item_ff.status_residue   <= req_chan.status_residue;
         in_item_ff.status_code      <= req_chan.status_code;
      end
   end

   assign status_good = (in_item_ff.status_signature == STATUS_SIGNATURE)
                     && (in_item_ff.status_tag == cfg.command_tag)
                     && (in_item_ff.status_residue == 32'd0)
                     && (in_item_ff.status_code == STATUS_GOOD);

   // phase update and result
   always_comb begin
      phase_in    = phase_ff;
      read_dir_in = read_dir_ff;
      data_len_in = data_len_ff;
      device_in   = device_ff;
      rsp_item_in = '0;
      rsp_item_in.action = ACT_NONE;
      if (op_type'(in_item_ff.op) == OP_START) begin
         rsp_item_in.target_address = in_item_ff.usb_addr;
         if (phase_ff != PH_IDLE) begin
            rsp_item_in.action = ACT_BUSY;
         end else begin
            read_dir_in = in_item_ff.direction;
            data_len_in = in_item_ff.data_bytes;
            device_in   = in_item_ff.usb_addr;
            phase_in    = PH_WRAPPER;
            rsp_item_in.action     = ACT_SEND_WRAPPER;
            rsp_item_in.byte_count = WRAPPER_BYTES;
            rsp_item_in.timeout_ms = cfg.short_timeout;
         end
      end else if (phase_ff != PH_IDLE) begin
         rsp_item_in.target_address = device_ff;
         rsp_item_in.close_pipes    = 1'b1;
         if (!in_item_ff.transfer_ok) begin
            phase_in = PH_IDLE;
            rsp_item_in.action = ACT_ERROR;
         end else begin
            unique case (phase_ff)
               PH_WRAPPER, PH_DATA: begin
                  if (phase_ff == PH_WRAPPER && data_len_ff != 32'd0) begin
                     phase_in = PH_DATA;
                     rsp_item_in.byte_count = data_len_ff;
                     if (read_dir_ff) begin
                        rsp_item_in.action     = ACT_READ_DATA;
                        rsp_item_in.timeout_ms = cfg.read_timeout;
                     end else begin
                        rsp_item_in.action     = ACT_WRITE_DATA;
                        rsp_item_in.timeout_ms = cfg.write_timeout;
                     end
                  end else begin
                     phase_in = PH_STATUS;
                     rsp_item_in.action     = ACT_READ_STATUS;
                     rsp_item_in.byte_count = STATUS_BYTES;
                     rsp_item_in.timeout_ms = cfg.short_timeout;
                  end
               end
               PH_STATUS: begin
                  phase_in = PH_IDLE;
                  rsp_item_in.action = status_good ? ACT_SUCCESS : ACT_ERROR;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         read_dir_ff <= 1'b0;
         data_len_ff <= 32'd0;
         device_ff   <= 7'd0;
      end else if (exe_fire) begin
         phase_ff    <= phase_in;
         read_dir_ff <= read_dir_in;
         data_len_ff <= data_len_in;
         device_ff   <= device_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exe_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exe_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.action         = rsp_item_ff.action;
   assign rsp_chan.target_address = rsp_item_ff.target_address;
   assign rsp_chan.byte_count     = rsp_item_ff.byte_count;
   assign rsp_chan.timeout_ms     = rsp_item_ff.timeout_ms;
   assign rsp_chan.close_pipes    = rsp_item_ff.close_pipes;

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> phase_ff == PH_IDLE)
      else $error("phase not idle after reset");

   a_busy_reject: assert property (@(posedge clock) disable iff (reset)
      (exe_fire && op_type'(in_item_ff.op) == OP_START && phase_ff != PH_IDLE)
      |=> (rsp_item_ff.action == ACT_BUSY && $stable(phase_ff)))
      else $error("start while busy not rejected");

   a_return_idle: assert property (@(posedge clock) disable iff (reset)
      (exe_fire && phase_ff != PH_IDLE && phase_in == PH_IDLE)
      |=> (rsp_item_ff.action == ACT_SUCCESS || rsp_item_ff.action == ACT_ERROR))
      else $error("return to idle without a final result");

   a_close_pipes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.close_pipes)
      |-> (rsp_item_ff.action != ACT_NONE && rsp_item_ff.action != ACT_SEND_WRAPPER
           && rsp_item_ff.action != ACT_BUSY))
      else $error("close_pipes on a result outside a running sequence");

endmodule

`default_nettype wire

### hdl/bulk_only_transport_sequencer.sv
// bulk_only_transport_sequencer: top level of the bulk-only transport sequencer
// depends on bot_pkg, bot_if, bot_csr and bot_seq
//
//  channel   | direction | handshake            | contents
//  req_chan  | in        | valid/ready          | start or completion item
//  rsp_chan  | out       | valid/ready          | one result item per request item
//  csr_*     | in        | write enable, no ack | tag and timeout registers
//
// one item per cycle sustained while rsp_chan does not stall; an item's result reaches rsp_chan
// through the input register and the result register around the phase logic
// reset is synchronous; phase idle, registers at their defaults, both stages empty
// a stalled result holds both stages; the input register still refills as the result drains
`timescale 1ns / 1ps
`default_nettype none

module bulk_only_transport_sequencer
   import bot_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   bot_req_if.sink                         req_chan,
   bot_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type cfg;

   bot_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bot_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

### tb/bot_result_checker.sv
// bot_result_checker: watches the request, result and register ports of the sequencer,
// predicts each result from its own copy of the phase and registers, and compares
// depends on bot_pkg and the bot_req_if / bot_rsp_if interfaces
`timescale 1ns / 1ps

module bot_result_checker
   import bot_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   bot_req_if                              req_mon,
   bot_rsp_if                              rsp_mon,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int unsigned                     fail_count,
   output int unsigned                     pending_results,
   output int unsigned                     results_checked,
   output int unsigned                     success_seen,
   output int unsigned                     error_seen,
   output int unsigned                     busy_seen
);

   localparam int unsigned MAX_REPORTED = 30;

   cfg_type      regs;
   phase_type    seq_phase;
   logic         read_dir;
   logic [31:0]  data_len;
   logic [6:0]   cur_device;
   rsp_item_type expected_responses[$];

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTED)
         $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, want, got);
   endtask

   function automatic rsp_item_type predict_response(input req_item_type it);
      rsp_item_type r;
      logic         status_good;
      r = '0;
      status_good = (it.status_signature == STATUS_SIGNATURE) &&
                    (it.status_tag == regs.command_tag) &&
                    (it.status_residue == 32'd0) && (it.status_code == STATUS_GOOD);
      if (it.op == OP_START) begin
         r.target_address = it.usb_addr;
         if (seq_phase != PH_IDLE) begin
            r.action = ACT_BUSY;
         end else begin
            read_dir     = it.direction;
            data_len     = it.data_bytes;
            cur_device   = it.usb_addr;
            seq_phase    = PH_WRAPPER;
            r.action     = ACT_SEND_WRAPPER;
            r.byte_count = WRAPPER_BYTES;
            r.timeout_ms = regs.short_timeout;
         end
      end else if (seq_phase == PH_IDLE) begin
         r.action = ACT_NONE;
      end else begin
         r.target_address = cur_device;
         r.close_pipes    = 1'b1;
         if (!it.transfer_ok) begin
            seq_phase = PH_IDLE;
            r.action  = ACT_ERROR;
         end else if (seq_phase == PH_WRAPPER && data_len != 32'd0) begin
            seq_phase    = PH_DATA;
            r.byte_count = data_len;
            if (read_dir) begin
               r.action     = ACT_READ_DATA;
               r.timeout_ms = regs.read_timeout;
            end else begin
               r.action     = ACT_WRITE_DATA;
               r.timeout_ms = regs.write_timeout;
            end
         end else if (seq_phase == PH_WRAPPER || seq_phase == PH_DATA) begin
            seq_phase    = PH_STATUS;
            r.action     = ACT_READ_STATUS;
            r.byte_count = STATUS_BYTES;
            r.timeout_ms = regs.short_timeout;
         end else begin
            seq_phase = PH_IDLE;
            r.action  = status_good ? ACT_SUCCESS : ACT_ERROR;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      req_item_type req;
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         regs.command_tag   = COMMAND_TAG_RESET;
         regs.short_timeout = SHORT_TIMEOUT_RESET;
         regs.read_timeout  = READ_TIMEOUT_RESET;
         regs.write_timeout = WRITE_TIMEOUT_RESET;
         seq_phase          = PH_IDLE;
         read_dir           = 1'b0;
         data_len           = '0;
         cur_device         = '0;
         expected_responses.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_COMMAND_TAG:   regs.command_tag   = csr_write_data;
               CSR_SHORT_TIMEOUT: regs.short_timeout = csr_write_data[15:0];
               CSR_READ_TIMEOUT:  regs.read_timeout  = csr_write_data[15:0];
               CSR_WRITE_TIMEOUT: regs.write_timeout = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.action         = rsp_mon.action;
            got.target_address = rsp_mon.target_address;
            got.byte_count     = rsp_mon.byte_count;
            got.timeout_ms     = rsp_mon.timeout_ms;
            got.close_pipes    = rsp_mon.close_pipes;
            if (expected_responses.size() == 0) begin
               report_mismatch("result with no request outstanding, action", '0,
                               32'(got.action));
            end else begin
               want = expected_responses.pop_front();
               results_checked++;
               if (got.action !== want.action)
                  report_mismatch("action", 32'(want.action), 32'(got.action));
               if (got.target_address !== want.target_address)
                  report_mismatch("target_address", 32'(want.target_address),
                                  32'(got.target_address));
               if (got.byte_count !== want.byte_count)
                  report_mismatch("byte_count", want.byte_count, got.byte_count);
               if (got.timeout_ms !== want.timeout_ms)
                  report_mismatch("timeout_ms", 32'(want.timeout_ms), 32'(got.timeout_ms));
               if (got.close_pipes !== want.close_pipes)
                  report_mismatch("close_pipes", 32'(want.close_pipes),
                                  32'(got.close_pipes));
            end
            if (got.action == ACT_SUCCESS) success_seen++;
            if (got.action == ACT_ERROR)   error_seen++;
            if (got.action == ACT_BUSY)    busy_seen++;
         end
         if (req_mon.valid && req_mon.ready) begin
            req.op               = req_mon.op;
            req.usb_addr         = req_mon.usb_addr;
            req.direction        = req_mon.direction;
            req.data_bytes       = req_mon.data_bytes;
            req.transfer_ok      = req_mon.transfer_ok;
            req.status_signature = req_mon.status_signature;
            req.status_tag       = req_mon.status_tag;
            req.status_residue   = req_mon.status_residue;
            req.status_code      = req_mon.status_code;
            expected_responses.push_back(predict_response(req));
         end
      end
      pending_results <= expected_responses.size();
   end

endmodule

### tb/testbench.sv
// testbench: drives start and completion items into the bulk-only transport sequencer
// under several register settings and idle/stall mixes; bot_result_checker judges results
// depends on bot_pkg, bot_if, the sequencer rtl and tb/bot_result_checker.sv
`timescale 1ns / 1ps

module testbench;
   import bot_pkg::*;

   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT   = 5000;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned ROUNDS           = 8;
   localparam int unsigned ROUND_ITEMS      = 160;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   int unsigned fail_count, pending_results, results_checked;
   int unsigned success_seen, error_seen, busy_seen;
   int unsigned items_sent;
   int unsigned settings_count;
   int unsigned sender_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned quiet_cycles;
   int unsigned hold_requests;
   cfg_type     cur_cfg;

   bot_req_if req_chan ();
   bot_rsp_if rsp_chan ();

   bulk_only_transport_sequencer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bot_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .results_checked  (results_checked),
      .success_seen     (success_seen),
      .error_seen       (error_seen),
      .busy_seen        (busy_seen)
   );

   always #2 clock = ~clock;

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned holds_served;
      holds_served   = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic req_item_type random_request();
      req_item_type r;
      r.op               = op_type'($urandom_range(1));
      r.usb_addr         = 7'($urandom_range(127));
      r.direction        = 1'($urandom_range(1));
      r.data_bytes       = $urandom;
      r.transfer_ok      = 1'($urandom_range(1));
      r.status_signature = $urandom;
      r.status_tag       = $urandom;
      r.status_residue   = $urandom;
      r.status_code      = 8'($urandom_range(255));
      return r;
   endfunction

   function automatic req_item_type start_item(input logic [6:0] addr, input logic dir,
                                               input logic [31:0] len);
      req_item_type r;
      r            = random_request();
      r.op         = OP_START;
      r.usb_addr   = addr;
      r.direction  = dir;
      r.data_bytes = len;
      return r;
   endfunction

   function automatic req_item_type done_item(input logic ok);
      req_item_type r;
      r             = random_request();
      r.op          = OP_COMPLETE;
      r.transfer_ok = ok;
      return r;
   endfunction

   function automatic req_item_type good_status();
      req_item_type r;
      r                  = done_item(1'b1);
      r.status_signature = STATUS_SIGNATURE;
      r.status_tag       = cur_cfg.command_tag;
      r.status_residue   = '0;
      r.status_code      = STATUS_GOOD;
      return r;
   endfunction

   task automatic push_request(input req_item_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.op               <= it.op;
      req_chan.usb_addr         <= it.usb_addr;
      req_chan.direction        <= it.direction;
      req_chan.data_bytes       <= it.data_bytes;
      req_chan.transfer_ok      <= it.transfer_ok;
      req_chan.status_signature <= it.status_signature;
      req_chan.status_tag       <= it.status_tag;
      req_chan.status_residue   <= it.status_residue;
      req_chan.status_code      <= it.status_code;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input cfg_type c);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_COMMAND_TAG;
      csr_write_data   <= c.command_tag;
      @(posedge clock);
      csr_index        <= CSR_SHORT_TIMEOUT;
      csr_write_data   <= {16'd0, c.short_timeout};
      @(posedge clock);
      csr_index        <= CSR_READ_TIMEOUT;
      csr_write_data   <= {16'd0, c.read_timeout};
      @(posedge clock);
      csr_index        <= CSR_WRITE_TIMEOUT;
      csr_write_data   <= {16'd0, c.write_timeout};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_cfg = c;
      settings_count++;
   endtask

   task automatic maybe_busy_start();
      if ($urandom_range(99) < 8)
         push_request(start_item(7'($urandom_range(127)), 1'($urandom_range(1)), $urandom));
   endtask

   // one command: start, wrapper, optional data, status, with random faults
   task automatic run_transaction();
      req_item_type it;
      int unsigned  pick;
      int unsigned  stages;
      logic [31:0]  len;
      if ($urandom_range(99) < 8) push_request(done_item(1'($urandom_range(1))));
      pick = $urandom_range(99);
      if (pick < 25)      len = '0;
      else if (pick < 32) len = '1;
      else if (pick < 45) len = $urandom;
      else                len = $urandom_range(4096, 1);
      push_request(start_item(7'($urandom_range(127)), 1'($urandom_range(1)), len));
      stages = (len != 0) ? 2 : 1;
      for (int s = 0; s < stages; s++) begin
         maybe_busy_start();
         if ($urandom_range(99) < 6) begin
            push_request(done_item(1'b0));
            return;
         end
         push_request(done_item(1'b1));
      end
      maybe_busy_start();
      it   = good_status();
      pick = $urandom_range(99);
      if (pick < 6)       it.transfer_ok = 1'b0;
      else if (pick < 12) it.status_signature ^= 32'd1 << $urandom_range(31);
      else if (pick < 18) it.status_tag ^= 32'd1 << $urandom_range(31);
      else if (pick < 24) it.status_residue = 32'd1 << $urandom_range(31);
      else if (pick < 30) it.status_code = 8'($urandom_range(255, 1));
      push_request(it);
   endtask

   task automatic run_directed();
      req_item_type it;
      // stray completions while idle
      it = done_item(1'b1);
      it.usb_addr = '1; it.data_bytes = '1; it.status_signature = '1;
      it.status_tag = '1; it.status_residue = '1; it.status_code = '1;
      push_request(it);
      push_request(done_item(1'b0));
      // zero length read: wrapper goes straight to status, good status
      push_request(start_item(7'd0, 1'b1, 32'd0));
      push_request(done_item(1'b1));
      push_request(good_status());
      // maximum length read with a start while busy, bad signature
      push_request(start_item(7'd127, 1'b1, '1));
      push_request(start_item(7'd85, 1'b0, 32'd5));
      push_request(done_item(1'b1));
      push_request(done_item(1'b1));
      it = good_status(); it.status_signature = '0;
      push_request(it);
      // one byte write, nonzero residue
      push_request(start_item(7'd1, 1'b0, 32'd1));
      push_request(done_item(1'b1));
      push_request(done_item(1'b1));
      it = good_status(); it.status_residue = 32'd1;
      push_request(it);
      // wrapper transfer fails
      push_request(start_item(7'd42, 1'b0, 32'd512));
      push_request(done_item(1'b0));
      // data transfer fails
      push_request(start_item(7'd99, 1'b1, 32'd8));
      push_request(done_item(1'b1));
      push_request(done_item(1'b0));
      // wrong tag, then failing status code, on zero length commands
      push_request(start_item(7'd64, 1'b0, 32'd0));
      push_request(done_item(1'b1));
      it = good_status(); it.status_tag = ~cur_cfg.command_tag;
      push_request(it);
      push_request(start_item(7'd2, 1'b1, 32'd0));
      push_request(done_item(1'b1));
      it = good_status(); it.status_code = '1;
      push_request(it);
   endtask

   initial begin
      cfg_type     c;
      int unsigned round_end;
      int unsigned mode;
      logic        pressure_done;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_chan.valid            = 1'b0;
      req_chan.op               = 1'b0;
      req_chan.usb_addr         = '0;
      req_chan.direction        = 1'b0;
      req_chan.data_bytes       = '0;
      req_chan.transfer_ok      = 1'b0;
      req_chan.status_signature = '0;
      req_chan.status_tag       = '0;
      req_chan.status_residue   = '0;
      req_chan.status_code      = '0;
      hold_requests   = 0;
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      items_sent      = 0;
      settings_count  = 1;
      cur_cfg.command_tag   = COMMAND_TAG_RESET;
      cur_cfg.short_timeout = SHORT_TIMEOUT_RESET;
      cur_cfg.read_timeout  = READ_TIMEOUT_RESET;
      cur_cfg.write_timeout = WRITE_TIMEOUT_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (int unsigned round = 0; round < ROUNDS; round++) begin
         drain_results();
         if (round == 0) begin
            c = '0;
         end else if (round == 1) begin
            c = '1;
         end else begin
            c.command_tag   = $urandom;
            c.short_timeout = 16'($urandom_range(65535));
            c.read_timeout  = 16'($urandom_range(65535));
            c.write_timeout = 16'($urandom_range(65535));
         end
         program_registers(c);
         mode = round % 4;
         sender_idle_pct = (mode == 1) ? 88 : (mode == 3) ? 28 : 0;
         recv_stall_pct  = (mode == 2) ? 88 : (mode == 3) ? 28 : 0;
         round_end     = items_sent + ROUND_ITEMS;
         pressure_done = 1'b0;
         while (items_sent < round_end) begin
            run_transaction();
            if (!pressure_done && items_sent >= round_end - ROUND_ITEMS / 2) begin
               pressure_done = 1'b1;
               if (round % 2 == 0) hold_requests++;
               else drain_results();
            end
         end
      end

      drain_results();
      $display("covered %0d request items over %0d register settings, idle/stall mixes",
               items_sent, settings_count);
      $display("checked %0d results: %0d success, %0d error, %0d busy reject",
               results_checked, success_seen, error_seen, busy_seen);
      if (fail_count == 0 && pending_results == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
